// ===== sv/wind_pulse_window_packer_macros.svh =====
// Assertion macros used by the checker of the wind pulse packer.
`ifndef WIND_PULSE_WINDOW_PACKER_MACROS_SVH
`define WIND_PULSE_WINDOW_PACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WPWP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WPWP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/wpwp_pkg.sv =====
package wpwp_pkg;

    // Window and message geometry.
    localparam int TICKS_PER_WINDOW    = 12;
    localparam int SAMPLES_PER_MESSAGE = 10;
    localparam int MSG_BYTES           = SAMPLES_PER_MESSAGE + 2;

    // Field widths fixed by the interface.
    localparam int COUNT_W = 8;
    localparam int VOLT_W  = 16;
    localparam int TEMP_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 4;
    localparam int PHASE_W = 4;

    // Width of an index into the sample store.
    localparam int SLOT_W = (SAMPLES_PER_MESSAGE > 1) ? $clog2(SAMPLES_PER_MESSAGE) : 1;

    // Fixed-point form of the 0.067056 wind scale factor: x * 4395 >> 16.
    localparam int SCALE_MUL   = 4395;
    localparam int SCALE_SHIFT = 16;
    localparam int PROD_W      = BYTE_W + SCALE_SHIFT;

    // Temperature clamp window and offset, in tenths of a degree.
    localparam int TEMP_LOW    = -300;
    localparam int TEMP_HIGH   = 720;
    localparam int TEMP_OFFSET = 300;

    // Byte positions of the two trailer bytes.
    localparam logic [POS_W-1:0] POS_VOLT = POS_W'(SAMPLES_PER_MESSAGE);
    localparam logic [POS_W-1:0] POS_TEMP = POS_W'(SAMPLES_PER_MESSAGE + 1);

    // One complete message, handed from the front end to the emitter.
    typedef struct packed {
        logic [SAMPLES_PER_MESSAGE-1:0][BYTE_W-1:0] samples;
        logic [BYTE_W-1:0]                          volt_byte;
        logic [BYTE_W-1:0]                          temp_byte;
    } t_msg;

    // Scale a summed pulse byte to wind units.
    function automatic logic [BYTE_W-1:0] scale_sample(input logic [BYTE_W-1:0] x);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(SCALE_MUL);
        return prod[PROD_W-1:SCALE_SHIFT];
    endfunction

    // Keep bits 4 to 11 of the supply voltage.
    function automatic logic [BYTE_W-1:0] volt_byte(input logic [VOLT_W-1:0] v);
        return v[BYTE_W+3:4];
    endfunction

    // Clamp, offset and quarter the temperature.
    function automatic logic [BYTE_W-1:0] temp_byte(input logic signed [TEMP_W-1:0] t);
        logic signed [TEMP_W-1:0] clamped;
        logic [TEMP_W-1:0]        shifted;
        if (t < TEMP_W'(TEMP_LOW)) begin
            clamped = TEMP_W'(TEMP_LOW);
        end else if (t > TEMP_W'(TEMP_HIGH)) begin
            clamped = TEMP_W'(TEMP_HIGH);
        end else begin
            clamped = t;
        end
        shifted = TEMP_W'(clamped + TEMP_W'(TEMP_OFFSET));
        return shifted[BYTE_W+1:2];
    endfunction

endpackage

// ===== sv/wpwp_front.sv =====
module wpwp_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [wpwp_pkg::COUNT_W-1:0]          i_pulse_count,
    input  logic [wpwp_pkg::VOLT_W-1:0]           i_supply_voltage,
    input  logic signed [wpwp_pkg::TEMP_W-1:0]    i_temperature,
    output logic                                  o_push,
    output wpwp_pkg::t_msg                        o_msg,
    input  logic                                  i_push_ready
);
    import wpwp_pkg::*;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [BYTE_W-1:0]  r_acc, n_acc;
    logic [BYTE_W-1:0]  r_store [SAMPLES_PER_MESSAGE];

    logic              accept;
    logic              win_end;
    logic              msg_end;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] scaled;

    // A tick is taken whenever the queue can absorb a message.
    assign o_ready = i_push_ready;
    assign accept  = i_valid && i_push_ready;

    // Running sum: the first tick of a window restarts it at zero.
    assign sum     = (r_phase == '0) ? '0 : BYTE_W'(r_acc + i_pulse_count);
    assign scaled  = scale_sample(sum);
    assign win_end = (r_phase == PHASE_W'(TICKS_PER_WINDOW - 1));
    assign msg_end = win_end && (r_slot == SLOT_W'(SAMPLES_PER_MESSAGE - 1));
    assign o_push  = accept && msg_end;

    // Window and slot counters.
    always_comb begin
        n_phase = r_phase;
        n_slot  = r_slot;
        n_acc   = r_acc;
        if (accept) begin
            n_acc = sum;
            if (win_end) begin
                n_phase = '0;
                n_slot  = msg_end ? '0 : SLOT_W'(r_slot + 1'b1);
            end else begin
                n_phase = PHASE_W'(r_phase + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_slot  <= '0;
        end else begin
            r_phase <= n_phase;
            r_slot  <= n_slot;
        end
        r_acc <= n_acc;
    end

    // Completed samples are kept until the message goes out.
    always_ff @(posedge i_clk) begin
        if (accept && win_end) begin
            r_store[r_slot] <= scaled;
        end
    end

    // Assemble the message; the newest sample bypasses the store.
    always_comb begin
        for (int i = 0; i < SAMPLES_PER_MESSAGE; i++) begin
            o_msg.samples[i] = (i == SAMPLES_PER_MESSAGE - 1) ? scaled : r_store[i];
        end
        o_msg.volt_byte = volt_byte(i_supply_voltage);
        o_msg.temp_byte = temp_byte(i_temperature);
    end

endmodule

// ===== sv/wpwp_queue.sv =====
module wpwp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wpwp_pkg::t_msg i_msg,
    output logic           o_push_ready,
    output logic           o_valid,
    output wpwp_pkg::t_msg o_msg,
    input  logic           i_pop
);
    import wpwp_pkg::*;

    // Two message entries, so one can be emitted while the next is built.
    t_msg       r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    assign o_push_ready = (r_count != 2'd2);
    assign o_valid      = (r_count != 2'd0);
    assign o_msg        = r_mem[r_rptr];

    // Pointer and occupancy update.
    always_comb begin
        n_wptr  = i_push ? ~r_wptr : r_wptr;
        n_rptr  = i_pop ? ~r_rptr : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_msg;
        end
    end

endmodule

// ===== sv/wpwp_back.sv =====
module wpwp_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_msg_valid,
    input  wpwp_pkg::t_msg                 i_msg,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [wpwp_pkg::BYTE_W-1:0]    o_byte_value,
    output logic [wpwp_pkg::POS_W-1:0]     o_byte_position,
    output logic                           o_last_of_message
);
    import wpwp_pkg::*;

    logic [POS_W-1:0]  r_idx, n_idx;
    logic              r_oval, n_oval;
    logic [BYTE_W-1:0] r_byte;
    logic [POS_W-1:0]  r_pos;
    logic              r_last;

    logic              emit;
    logic              at_end;
    logic [BYTE_W-1:0] sel_byte;

    // A word is loaded when a message waits and the output register is free.
    assign emit   = i_msg_valid && (!r_oval || i_ready);
    assign at_end = (r_idx == POS_W'(MSG_BYTES - 1));
    assign o_pop  = emit && at_end;

    // Pick the byte for the current position.
    always_comb begin
        if (r_idx == POS_VOLT) begin
            sel_byte = i_msg.volt_byte;
        end else if (r_idx == POS_TEMP) begin
            sel_byte = i_msg.temp_byte;
        end else begin
            sel_byte = i_msg.samples[r_idx[SLOT_W-1:0]];
        end
    end

    // Position counter and output valid.
    always_comb begin
        n_idx  = r_idx;
        n_oval = r_oval;
        if (emit) begin
            n_idx  = at_end ? '0 : POS_W'(r_idx + 1'b1);
            n_oval = 1'b1;
        end else if (i_ready) begin
            n_oval = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_oval <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_oval <= n_oval;
        end
        if (emit) begin
            r_byte <= sel_byte;
            r_pos  <= r_idx;
            r_last <= at_end;
        end
    end

    assign o_valid           = r_oval;
    assign o_byte_value      = r_byte;
    assign o_byte_position   = r_pos;
    assign o_last_of_message = r_last;

endmodule

// ===== sv/wind_pulse_window_packer.sv =====
// Channel   Direction  Handshake            Word
// ticks     in         i_valid / o_ready    pulse count, supply voltage, temperature
// bytes     out        o_valid / i_ready    byte value, byte position, last flag
//
// One tick is accepted per cycle while o_ready is high; a tick that completes
// a message hands it to a two-entry message queue, and the emitter sends its
// 12 bytes one per cycle, while i_ready is high, through an output register.
// o_ready drops only while both queue entries hold messages not yet fully sent.
// Synchronous active-low reset clears the counters, the queue and the output valid.
module wind_pulse_window_packer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [wpwp_pkg::COUNT_W-1:0]        i_pulse_count,
    input  logic [wpwp_pkg::VOLT_W-1:0]         i_supply_voltage,
    input  logic signed [wpwp_pkg::TEMP_W-1:0]  i_temperature,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [wpwp_pkg::BYTE_W-1:0]         o_byte_value,
    output logic [wpwp_pkg::POS_W-1:0]          o_byte_position,
    output logic                                o_last_of_message
);
    import wpwp_pkg::*;

    logic push;
    logic push_ready;
    logic msg_valid;
    logic pop;
    t_msg front_msg;
    t_msg head_msg;

    // Tick accumulation and message assembly.
    wpwp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_pulse_count    (i_pulse_count),
        .i_supply_voltage (i_supply_voltage),
        .i_temperature    (i_temperature),
        .o_push           (push),
        .o_msg            (front_msg),
        .i_push_ready     (push_ready)
    );

    // Message queue between the two sides.
    wpwp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_msg        (front_msg),
        .o_push_ready (push_ready),
        .o_valid      (msg_valid),
        .o_msg        (head_msg),
        .i_pop        (pop)
    );

    // Byte emitter with registered output.
    wpwp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_msg_valid       (msg_valid),
        .i_msg             (head_msg),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_byte_value      (o_byte_value),
        .o_byte_position   (o_byte_position),
        .o_last_of_message (o_last_of_message)
    );

endmodule

// ===== sv/wpwp_checker.sv =====
`include "wind_pulse_window_packer_macros.svh"

module wpwp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic [wpwp_pkg::COUNT_W-1:0]        i_pulse_count,
    input logic [wpwp_pkg::VOLT_W-1:0]         i_supply_voltage,
    input logic signed [wpwp_pkg::TEMP_W-1:0]  i_temperature,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic [wpwp_pkg::BYTE_W-1:0]         o_byte_value,
    input logic [wpwp_pkg::POS_W-1:0]          o_byte_position,
    input logic                                o_last_of_message
);
    import wpwp_pkg::*;

    logic [POS_W-1:0]                 r_want_pos;

    logic                             in_stall;
    logic                             out_stall;
    logic                             out_take;
    logic                             last_ok;
    logic                             next_ok;
    logic [COUNT_W+VOLT_W+TEMP_W:0]   in_word;
    logic [BYTE_W+POS_W+1:0]          out_word;

    // Handshake state and the words carried on both channels.
    assign in_stall  = i_valid && !o_ready;
    assign out_stall = o_valid && !i_ready;
    assign out_take  = o_valid && i_ready;
    assign in_word   = {i_valid, i_pulse_count, i_supply_voltage, i_temperature};
    assign out_word  = {o_valid, o_byte_value, o_byte_position, o_last_of_message};

    // The last flag marks exactly the temperature byte.
    assign last_ok = (o_last_of_message == (o_byte_position == POS_TEMP));

    // After an accepted word the next one is one position on, or zero after the last.
    always_ff @(posedge i_clk) begin
        r_want_pos <= o_last_of_message ? '0 : POS_W'(o_byte_position + 1'b1);
    end
    assign next_ok = !o_valid || (o_byte_position == r_want_pos);

    // A waiting tick word holds.
    `WPWP_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_stall, $stable(in_word), "tick word not held")

    // A stalled output word holds.
    `WPWP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, $stable(out_word), "byte word not held")

    // The last flag sits on the final byte only.
    `WPWP_ASSERT_NOW(a_last_pos, i_clk, i_rst_n, o_valid, last_ok, "last flag not on final byte")

    // Positions advance by one and restart at zero after a message.
    `WPWP_ASSERT_NEXT(a_pos_seq, i_clk, i_rst_n, out_take, next_ok, "byte position out of order")

endmodule

bind wind_pulse_window_packer wpwp_checker u_wpwp_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import wpwp_pkg::*;

    localparam int RAND_TICKS   = 140;
    localparam int RAND_MSGS    = 1;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 30;

    // One word of the packed message as the receiver should see it.
    typedef struct {
        logic [BYTE_W-1:0] value;
        logic [POS_W-1:0]  pos;
        logic              last;
    } t_msg_byte;

    // One row of the directed ticks; the trailer bytes are typed in on message closers.
    typedef struct {
        logic [COUNT_W-1:0]       count;
        logic [VOLT_W-1:0]        volt;
        logic signed [TEMP_W-1:0] temp;
        int                       reps;
        bit                       typed;
        logic [BYTE_W-1:0]        volt_exp;
        logic [BYTE_W-1:0]        temp_exp;
    } t_tick_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [COUNT_W-1:0]       i_pulse_count = '0;
    logic [VOLT_W-1:0]        i_supply_voltage = '0;
    logic signed [TEMP_W-1:0] i_temperature = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [BYTE_W-1:0]        o_byte_value;
    logic [POS_W-1:0]         o_byte_position;
    logic                     o_last_of_message;

    // Predictor state: window phase, sample slot and the finished samples.
    logic [PHASE_W-1:0] win_phase = '0;
    logic [POS_W-1:0]   win_slot = '0;
    logic [BYTE_W-1:0]  wind_samples [SAMPLES_PER_MESSAGE];

    t_msg_byte   pending_bytes [$];
    t_tick_row   dir_rows [0:12];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          rx_stall = 0;

    wind_pulse_window_packer DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_pulse_count     (i_pulse_count),
        .i_supply_voltage  (i_supply_voltage),
        .i_temperature     (i_temperature),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_byte_value      (o_byte_value),
        .o_byte_position   (o_byte_position),
        .o_last_of_message (o_last_of_message)
    );

    // 4 ns clock.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Quiet stretches with no idling on either side.
    function automatic bit calm_now();
        return ((cycle_count / 256) % 4) == 0;
    endfunction

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_idle();
        int r;
        if (calm_now()) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    // Pulse counts lean on zero, full scale and small values.
    function automatic logic [COUNT_W-1:0] rand_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return ($urandom_range(0, 1) != 0) ? {COUNT_W{1'b1}} : '0;
        end else if (r < 40) begin
            return COUNT_W'($urandom_range(0, 15));
        end
        return COUNT_W'($urandom);
    endfunction

    // Voltages hit the edges of the kept bit field now and then.
    function automatic logic [VOLT_W-1:0] rand_volt();
        logic [VOLT_W-1:0] edges [4];
        edges = '{16'h0000, 16'hFFFF, 16'h0FFF, 16'h1000};
        if ($urandom_range(0, 99) < 20) begin
            return edges[$urandom_range(0, 3)];
        end
        return VOLT_W'($urandom);
    endfunction

    // Temperatures: clamp edges, values near the window and the full range.
    function automatic logic signed [TEMP_W-1:0] rand_temp();
        int edges [10];
        int r;
        edges = '{-32768, -301, -300, -299, -1, 0, 719, 720, 721, 32767};
        r = $urandom_range(0, 99);
        if (r < 25) begin
            return TEMP_W'(edges[$urandom_range(0, 9)]);
        end else if (r < 75) begin
            return TEMP_W'($urandom_range(0, 1060) - 320);
        end
        return TEMP_W'($urandom);
    endfunction

    // Advance the window by one tick and queue the message it completes, if any.
    task automatic pack_tick(input logic [COUNT_W-1:0] count,
                             input logic [VOLT_W-1:0] volt,
                             input logic signed [TEMP_W-1:0] temp,
                             input bit typed,
                             input logic [BYTE_W-1:0] volt_exp,
                             input logic [BYTE_W-1:0] temp_exp,
                             output bit closed);
        logic [PROD_W-1:0] prod;
        t_msg_byte         mb;
        int                t;
        closed = 1'b0;
        if (win_phase == 0) begin
            wind_samples[win_slot] = '0;
        end else begin
            wind_samples[win_slot] = wind_samples[win_slot] + count;
        end
        if (win_phase >= PHASE_W'(TICKS_PER_WINDOW - 1)) begin
            prod = PROD_W'(wind_samples[win_slot]) * PROD_W'(SCALE_MUL);
            wind_samples[win_slot] = BYTE_W'(prod >> SCALE_SHIFT);
            if (win_slot == POS_W'(SAMPLES_PER_MESSAGE - 1)) begin
                for (int i = 0; i < SAMPLES_PER_MESSAGE; i++) begin
                    mb.value = wind_samples[i];
                    mb.pos   = POS_W'(i);
                    mb.last  = 1'b0;
                    pending_bytes.push_back(mb);
                end
                // Voltage keeps bits 4 to 11 only.
                mb.value = typed ? volt_exp : volt[11:4];
                mb.pos   = POS_VOLT;
                mb.last  = 1'b0;
                pending_bytes.push_back(mb);
                // Temperature is clamped, offset and divided by four.
                t = temp;
                if (t < TEMP_LOW) begin
                    t = TEMP_LOW;
                end
                if (t > TEMP_HIGH) begin
                    t = TEMP_HIGH;
                end
                t = (t + TEMP_OFFSET) >> 2;
                mb.value = typed ? temp_exp : BYTE_W'(t);
                mb.pos   = POS_TEMP;
                mb.last  = 1'b1;
                pending_bytes.push_back(mb);
                win_slot = '0;
                closed = 1'b1;
            end else begin
                win_slot = win_slot + 1'b1;
            end
            win_phase = '0;
        end else begin
            win_phase = win_phase + 1'b1;
        end
    endtask

    // Present one tick and hold it until the block takes it.
    task automatic send_tick(input logic [COUNT_W-1:0] count,
                             input logic [VOLT_W-1:0] volt,
                             input logic signed [TEMP_W-1:0] temp,
                             input bit typed,
                             input logic [BYTE_W-1:0] volt_exp,
                             input logic [BYTE_W-1:0] temp_exp,
                             output bit closed);
        i_valid          <= 1'b1;
        i_pulse_count    <= count;
        i_supply_voltage <= volt;
        i_temperature    <= temp;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        pack_tick(count, volt, temp, typed, volt_exp, temp_exp, closed);
    endtask

    // Random pause between ticks; valid stays up when there is none.
    task automatic idle_gap();
        int n;
        n = pick_idle();
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every queued byte has come out.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_bytes.size() != 0);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Receiver side: random stalls on the byte channel.
    always @(posedge i_clk) begin : byte_sink
        int n;
        if (rx_stall > 0) begin
            i_ready <= 1'b0;
            rx_stall--;
        end else begin
            n = pick_idle();
            if (n == 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                rx_stall = n - 1;
            end
        end
    end

    // Compare every accepted word with the oldest expected byte.
    always @(posedge i_clk) begin : byte_check
        t_msg_byte want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_bytes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, expected none, actual value %0d pos %0d",
                         $time, o_byte_value, o_byte_position);
            end else begin
                want = pending_bytes.pop_front();
                check_field("byte_value", want.value, o_byte_value);
                check_field("byte_position", want.pos, o_byte_position);
                check_field("last_of_message", want.last, o_last_of_message);
            end
        end
    end

    // Cycle limit for a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d bytes outstanding", $time,
                     pending_bytes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_tick_row row;
        bit        closed;
        int        rand_ticks;
        int        rand_msgs;

        // Ten windows make one message. The first four windows cover the dropped
        // first tick, wraparound of a full-scale sum, the largest unwrapped sum and
        // a sum that wraps to zero. The closing tick carries extreme trailer values.
        dir_rows = '{
            '{8'd255, 16'h1234,  16'sd0,      1,   1'b0, 8'd0,   8'd0},
            '{8'd0,   16'h1234,  16'sd0,      11,  1'b0, 8'd0,   8'd0},
            '{8'd0,   16'h1234,  16'sd0,      1,   1'b0, 8'd0,   8'd0},
            '{8'd255, 16'h1234,  16'sd0,      11,  1'b0, 8'd0,   8'd0},
            '{8'd0,   16'h1234,  16'sd0,      1,   1'b0, 8'd0,   8'd0},
            '{8'd25,  16'h1234,  16'sd0,      10,  1'b0, 8'd0,   8'd0},
            '{8'd5,   16'h1234,  16'sd0,      1,   1'b0, 8'd0,   8'd0},
            '{8'd0,   16'h1234,  16'sd0,      1,   1'b0, 8'd0,   8'd0},
            '{8'd25,  16'h1234,  16'sd0,      10,  1'b0, 8'd0,   8'd0},
            '{8'd6,   16'h1234,  16'sd0,      1,   1'b0, 8'd0,   8'd0},
            '{8'd7,   16'h1234,  16'sd0,      60,  1'b0, 8'd0,   8'd0},
            '{8'd128, 16'h1234,  16'sd0,      11,  1'b0, 8'd0,   8'd0},
            '{8'd128, 16'hFFFF,  16'sh8000,   1,   1'b1, 8'd255, 8'd0}
        };

        // Hold reset, then release it.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed ticks.
        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            for (int k = 0; k < row.reps; k++) begin
                send_tick(row.count, row.volt, row.temp, row.typed, row.volt_exp,
                          row.temp_exp, closed);
                idle_gap();
            end
        end
        wait_drained();

        // Random ticks until enough messages have gone through.
        rand_ticks = 0;
        rand_msgs  = 0;
        while (rand_ticks < RAND_TICKS || rand_msgs < RAND_MSGS) begin
            send_tick(rand_count(), rand_volt(), rand_temp(), 1'b0, '0, '0, closed);
            rand_ticks++;
            if (closed) begin
                rand_msgs++;
            end
            if (closed && $urandom_range(0, 3) == 0) begin
                wait_drained();
            end else begin
                idle_gap();
            end
        end

        // Let the last message out, then watch for stray words.
        wait_drained();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== wind_pulse_window_packer.f =====
+incdir+sv
sv/wpwp_pkg.sv
sv/wpwp_front.sv
sv/wpwp_queue.sv
sv/wpwp_back.sv
sv/wind_pulse_window_packer.sv
sv/wpwp_checker.sv
bench/tb_top.sv
